>>> hw/rtl/srrr_pkg.sv
package srrr_pkg;

	localparam int DEF_WINDOW_DEPTH = 16;
	localparam int DEF_HANDLE_BITS  = 16;

	localparam int SEQ_W    = 32;
	localparam int HDL_W    = 16;
	localparam int FILE_W   = 16;
	localparam int WSIZE_W  = 5;

	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd16;

	localparam logic [1:0] FUNC_SYN  = 2'd0;
	localparam logic [1:0] FUNC_FIN  = 2'd1;
	localparam logic [1:0] FUNC_DATA = 2'd2;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		logic [1:0]       func;
		logic [SEQ_W-1:0] seq_num;
		logic             crc_ok;
		logic [HDL_W-1:0] packet_handle;
	} pkt_beat_t;

	typedef struct packed {
		logic              kind;
		logic [SEQ_W-1:0]  ack_seq;
		logic [HDL_W-1:0]  delivered_handle;
		logic [FILE_W-1:0] file_index;
		logic              last;
	} res_beat_t;

endpackage

>>> hw/rtl/selective_repeat_receive_reorder_top.sv
// selective-repeat receiver: window bookkeeping and in-order delivery
// pkt channel (pkt_valid / pkt_stall / pkt): one packet descriptor per beat
//   (SYN, FIN or DATA with sequence number, crc flag and payload handle)
// res channel (res_valid / res_stall / res): acknowledgements and in-order
//   deliveries; the last beat caused by a packet has last set
// cfg_wen / cfg_wdata write the window size; write it only while idle
// one packet is worked on at a time; pkt_stall is high while it is in flight
// a packet passes S_DECIDE, then S_COUNT for an in-order DATA packet, then
//   S_ACK, where its first result is loaded into the output register
// an in-order DATA packet also walks the slot valid bits, one slot a cycle,
//   to find the run length r, then for each delivered slot reads the handle
//   memory in S_DREAD and loads the handle into the output in S_DEMIT
// handles live in a circular buffer memory; the window slides by moving the
//   head pointer, valid bits sit in flops
// reset clears the window, valid bits and file counter at once; there is no
//   clearing pass and the block takes a packet in the first cycle after reset
// when res_stall is high the pending result holds in the output register and
//   the sequencer waits; the next packet may be taken while the final result
//   of the previous one still waits
module selective_repeat_receive_reorder_top #(
	parameter int WINDOW_DEPTH = srrr_pkg::DEF_WINDOW_DEPTH,
	parameter int HANDLE_BITS  = srrr_pkg::DEF_HANDLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pkt_valid,
	output logic                              pkt_stall,
	input  srrr_pkg::pkt_beat_t               pkt,
	output logic                              res_valid,
	input  logic                              res_stall,
	output srrr_pkg::res_beat_t               res,
	input  logic                              cfg_wen,
	input  logic [srrr_pkg::WSIZE_W-1:0]      cfg_wdata
);

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SEQ_W = srrr_pkg::SEQ_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_COUNT,
		S_ACK,
		S_DREAD,
		S_DEMIT
	} state_t;

	state_t                       state_q;
	srrr_pkg::pkt_beat_t          item_s1;
	logic [srrr_pkg::WSIZE_W-1:0] ws_q;
	logic [SEQ_W-1:0]             base_q;
	logic [IDX_W-1:0]             head_q;
	logic [WINDOW_DEPTH-1:0]      valid_q;
	logic [srrr_pkg::FILE_W-1:0]  fcnt_q;
	logic                         await_q;
	logic [SEQ_W-1:0]             open_q;
	logic [CNT_W-1:0]             run_q;
	logic [CNT_W-1:0]             idx_q;
	logic                         deliver_q;
	logic [SEQ_W-1:0]             ack_q;
	logic                         res_valid_q;
	srrr_pkg::res_beat_t          res_q;

	logic [HANDLE_BITS-1:0]       mem [WINDOW_DEPTH];
	logic [HANDLE_BITS-1:0]       rdata_s1;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic                         mem_re;
	logic [IDX_W-1:0]             mem_raddr;

	logic [CNT_W-1:0]             w_eff;
	logic [SEQ_W:0]               win_end;
	logic                         in_win;
	logic                         below;
	logic                         at_base;
	logic [CNT_W-1:0]             off;
	logic                         out_free;
	logic                         res_load;
	logic                         data_ok;
	logic [IDX_W-1:0]             run_idx;
	logic [IDX_W-1:0]             cur_idx;
	logic                         last_dlv;

	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] h,
			input logic [CNT_W-1:0] x);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(x);
		if (s >= (CNT_W+1)'(WINDOW_DEPTH)) begin
			s = s - (CNT_W+1)'(WINDOW_DEPTH);
		end
		return IDX_W'(s);
	endfunction

	always_comb begin
		if (ws_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (int'(ws_q) > WINDOW_DEPTH) begin
			w_eff = CNT_W'(WINDOW_DEPTH);
		end else begin
			w_eff = CNT_W'(ws_q);
		end
	end

	assign win_end  = {1'b0, base_q} + (SEQ_W+1)'(w_eff);
	assign in_win   = {1'b0, item_s1.seq_num} < win_end;
	assign below    = item_s1.seq_num < base_q;
	assign at_base  = item_s1.seq_num == base_q;
	assign off      = CNT_W'(item_s1.seq_num - base_q);
	assign data_ok  = item_s1.crc_ok && in_win && !below;
	assign out_free = !res_valid_q || !res_stall;
	assign res_load = out_free && ((state_q == S_ACK) || (state_q == S_DEMIT));
	assign run_idx  = wrap(head_q, run_q);
	assign cur_idx  = wrap(head_q, idx_q);
	assign last_dlv = (idx_q + CNT_W'(1)) == run_q;

	assign mem_we    = (state_q == S_DECIDE) && (item_s1.func == srrr_pkg::FUNC_DATA)
		&& data_ok;
	assign mem_waddr = at_base ? head_q : wrap(head_q, off);
	assign mem_re    = (state_q == S_DREAD);
	assign mem_raddr = cur_idx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= HANDLE_BITS'(item_s1.packet_handle);
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_s1     <= '0;
			ws_q        <= srrr_pkg::WSIZE_RESET;
			base_q      <= '0;
			head_q      <= '0;
			valid_q     <= '0;
			fcnt_q      <= '0;
			await_q     <= 1'b1;
			open_q      <= '0;
			run_q       <= '0;
			idx_q       <= '0;
			deliver_q   <= 1'b0;
			ack_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_wen) begin
				ws_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pkt_valid) begin
						item_s1 <= pkt;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (item_s1.func)
						srrr_pkg::FUNC_SYN: begin
							open_q    <= item_s1.seq_num;
							base_q    <= '0;
							valid_q   <= '0;
							await_q   <= 1'b1;
							ack_q     <= item_s1.seq_num;
							deliver_q <= 1'b0;
							state_q   <= S_ACK;
						end
						srrr_pkg::FUNC_FIN: begin
							if (await_q && (open_q == item_s1.seq_num) && (fcnt_q != '1)) begin
								fcnt_q <= fcnt_q + 1'b1;
							end
							await_q   <= 1'b0;
							ack_q     <= item_s1.seq_num;
							deliver_q <= 1'b0;
							state_q   <= S_ACK;
						end
						srrr_pkg::FUNC_DATA: begin
							ack_q <= base_q;
							if (!item_s1.crc_ok || !in_win) begin
								deliver_q <= 1'b0;
								state_q   <= S_IDLE;
							end else if (at_base) begin
								valid_q[head_q] <= 1'b1;
								run_q           <= CNT_W'(1);
								deliver_q       <= 1'b1;
								state_q         <= S_COUNT;
							end else begin
								if (!below) begin
									valid_q[mem_waddr] <= 1'b1;
								end
								deliver_q <= 1'b0;
								state_q   <= S_ACK;
							end
						end
						default: begin
							deliver_q <= 1'b0;
							state_q   <= S_IDLE;
						end
					endcase
				end
				S_COUNT: begin
					if ((run_q < w_eff) && valid_q[run_idx]) begin
						run_q <= run_q + CNT_W'(1);
					end else begin
						ack_q   <= base_q + SEQ_W'(run_q);
						state_q <= S_ACK;
					end
				end
				S_ACK: begin
					if (out_free) begin
						res_q.kind             <= srrr_pkg::KIND_ACK;
						res_q.ack_seq          <= ack_q;
						res_q.delivered_handle <= '0;
						res_q.file_index       <= '0;
						res_q.last             <= !deliver_q;
						if (deliver_q) begin
							base_q  <= ack_q;
							idx_q   <= '0;
							state_q <= S_DREAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DREAD: begin
					state_q <= S_DEMIT;
				end
				S_DEMIT: begin
					if (out_free) begin
						res_q.kind             <= srrr_pkg::KIND_DATA;
						res_q.ack_seq          <= '0;
						res_q.delivered_handle <= srrr_pkg::HDL_W'(rdata_s1);
						res_q.file_index       <= fcnt_q;
						res_q.last             <= last_dlv;
						valid_q[cur_idx]       <= 1'b0;
						if (last_dlv) begin
							head_q  <= run_idx;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_DREAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign pkt_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> hw/rtl/srrr_checker.sv
module srrr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pkt_valid,
	input logic                pkt_stall,
	input logic                res_valid,
	input logic                res_stall,
	input srrr_pkg::res_beat_t res
);

	// a result beat waits while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result beat dropped or changed under stall");

	// only the fields of its kind are nonzero
	a_res_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res.kind == srrr_pkg::KIND_ACK) && (res.delivered_handle == '0)
			&& (res.file_index == '0)) || ((res.kind == srrr_pkg::KIND_DATA)
			&& (res.ack_seq == '0)))
		else $error("result beat carries fields of the other kind");

	// reset leaves nothing pending and the packet side open
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !res_valid && !pkt_stall)
		else $error("reset did not clear the channels");

	// one packet at a time
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_stall |=> pkt_stall)
		else $error("packet side open right after a packet beat");

	// a beat that is not the last of its packet keeps the packet side closed
	a_delivery_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> pkt_stall)
		else $error("packet side open during in-order delivery");

endmodule

bind selective_repeat_receive_reorder_top srrr_checker u_srrr_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import srrr_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int SETTLE = 64;
	localparam longint LIMIT = 5000000;
	localparam int RANDOM_ITEMS = 340;

	class reorder_scoreboard;
		res_beat_t expected_q[$];
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] opened;
		bit [15:0] occupied;
		logic [HDL_W-1:0] held[16];
		logic [FILE_W-1:0] files;
		bit fin_pending;
		logic [WSIZE_W-1:0] wsize;
		int mismatches;

		function new();
			base = '0;
			opened = '0;
			occupied = '0;
			files = '0;
			fin_pending = 1'b1;
			wsize = WSIZE_RESET;
			mismatches = 0;
		endfunction

		function void set_window(logic [WSIZE_W-1:0] v);
			wsize = v;
		endfunction

		function int span();
			if (wsize == 0)
				return 1;
			if (wsize > 16)
				return 16;
			return int'(wsize);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push(logic k, logic [SEQ_W-1:0] a, logic [HDL_W-1:0] h,
				logic [FILE_W-1:0] f, logic l);
			res_beat_t b;
			b.kind = k;
			b.ack_seq = a;
			b.delivered_handle = h;
			b.file_index = f;
			b.last = l;
			expected_q.push_back(b);
		endfunction

		function void note_packet(pkt_beat_t p);
			int w;
			int r;
			int i;
			logic [SEQ_W-1:0] off;
			w = span();
			case (p.func)
				FUNC_SYN: begin
					opened = p.seq_num;
					base = '0;
					occupied = '0;
					fin_pending = 1'b1;
					push(KIND_ACK, p.seq_num, '0, '0, 1'b1);
				end
				FUNC_FIN: begin
					if (fin_pending && opened == p.seq_num && files != 16'hFFFF)
						files = files + 1'b1;
					fin_pending = 1'b0;
					push(KIND_ACK, p.seq_num, '0, '0, 1'b1);
				end
				FUNC_DATA: begin
					if (!p.crc_ok)
						return;
					if ({1'b0, p.seq_num} >= {1'b0, base} + 33'(w))
						return;
					if (p.seq_num < base) begin
						push(KIND_ACK, base, '0, '0, 1'b1);
					end else if (p.seq_num > base) begin
						off = p.seq_num - base;
						push(KIND_ACK, base, '0, '0, 1'b1);
						held[off[3:0]] = p.packet_handle;
						occupied[off[3:0]] = 1'b1;
					end else begin
						held[0] = p.packet_handle;
						occupied[0] = 1'b1;
						r = 0;
						while (r < w && occupied[r])
							r++;
						push(KIND_ACK, base + SEQ_W'(r), '0, '0, r == 0);
						for (i = 0; i < r; i++)
							push(KIND_DATA, '0, held[i], files, i + 1 == r);
						for (i = 0; i < 16; i++) begin
							if (i + r < 16) begin
								occupied[i] = occupied[i + r];
								held[i] = held[i + r];
							end else begin
								occupied[i] = 1'b0;
							end
						end
						base = base + SEQ_W'(r);
					end
				end
				default: ;
			endcase
		endfunction

		function void flag(string what, res_beat_t want, res_beat_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: kind %0d/%0d ack %h/%h handle %h/%h file %0d/%0d last %0d/%0d",
					what, want.kind, got.kind, want.ack_seq, got.ack_seq,
					want.delivered_handle, got.delivered_handle,
					want.file_index, got.file_index, want.last, got.last);
		endfunction

		function void check_result(res_beat_t got);
			res_beat_t want;
			if (expected_q.size() == 0) begin
				flag("unexpected beat (expected/actual)", '0, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind || got.ack_seq !== want.ack_seq ||
					got.delivered_handle !== want.delivered_handle ||
					got.file_index !== want.file_index || got.last !== want.last)
				flag("result beat differs (expected/actual)", want, got);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pkt_valid = 1'b0;
	logic pkt_stall;
	pkt_beat_t pkt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_beat_t res;
	logic cfg_wen = 1'b0;
	logic [WSIZE_W-1:0] cfg_wdata = WSIZE_RESET;

	reorder_scoreboard sb = new();
	bit calm = 1'b0;
	int items_sent = 0;
	int stall_left = 0;
	longint cycles = 0;

	selective_repeat_receive_reorder_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt(pkt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("selective_repeat_receive_reorder_top: mismatch");
			$finish;
		end
	end

	// result side with random backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				sb.check_result(res);
				stall_left = calm ? 0 : $urandom_range(0, 4);
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 4);
			end
			res_stall <= (stall_left > 0);
		end
	end

	task automatic send_packet(input logic [1:0] f, input logic [SEQ_W-1:0] s,
			input logic ok, input logic [HDL_W-1:0] h);
		pkt_beat_t p;
		int gap;
		p.func = f;
		p.seq_num = s;
		p.crc_ok = ok;
		p.packet_handle = h;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			pkt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_valid <= 1'b1;
		pkt <= p;
		do @(posedge clk); while (pkt_stall);
		sb.note_packet(p);
		if (f != FUNC_NONE)
			items_sent++;
	endtask

	task automatic pause_until_drained();
		pkt_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window(input logic [WSIZE_W-1:0] v);
		pause_until_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_window(v);
		cfg_wen <= 1'b0;
	endtask

	task automatic send_data(input logic [SEQ_W-1:0] s);
		send_packet(FUNC_DATA, s, 1'b1, HDL_W'($urandom()));
	endtask

	// one transfer: SYN (usually), shuffled chunks of up to a window, retransmits and noise, FIN
	task automatic run_transfer(input int n);
		logic [SEQ_W-1:0] s;
		int w;
		int c;
		int len;
		int j;
		int k;
		int tmp;
		int order[16];
		case ($urandom_range(0, 3))
			0: s = $urandom_range(0, 3);
			1: s = 32'hFFFFFFFF;
			default: s = $urandom();
		endcase
		w = sb.span();
		calm = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) != 0)
			send_packet(FUNC_SYN, s, 1'($urandom()), HDL_W'($urandom()));
		for (c = 0; c < n; c += len) begin
			len = (n - c < w) ? n - c : w;
			len = $urandom_range(1, len);
			for (j = 0; j < len; j++)
				order[j] = c + j;
			for (j = len - 1; j > 0; j--) begin
				k = $urandom_range(0, j);
				tmp = order[j];
				order[j] = order[k];
				order[k] = tmp;
			end
			for (j = 0; j < len; j++) begin
				case ($urandom_range(0, 19))
					0: send_packet(2'($urandom_range(0, 3)), $urandom(), 1'($urandom()),
						HDL_W'($urandom()));
					1, 2: send_packet(FUNC_DATA, order[j], 1'b0, HDL_W'($urandom()));
					3: send_data(c + w + $urandom_range(0, 100));
					4: send_data($urandom_range(0, c + j));
					default: ;
				endcase
				send_data(order[j]);
			end
		end
		send_packet(FUNC_FIN, ($urandom_range(0, 4) == 0) ? s ^ 32'h1 : s,
			1'($urandom()), HDL_W'($urandom()));
	endtask

	initial begin
		logic [WSIZE_W-1:0] windows[10];
		int ph;
		int k;
		int first;
		windows = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd7, 5'd3, 5'd12, 5'd17, 5'd5, 5'd16};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		send_packet(FUNC_NONE, 32'h0, 1'b1, 16'h1234);
		send_packet(FUNC_SYN, 32'hFFFFFFFF, 1'b1, 16'h0000);
		send_packet(FUNC_FIN, 32'hFFFFFFFF, 1'b0, 16'hFFFF);
		send_packet(FUNC_FIN, 32'hFFFFFFFF, 1'b1, 16'h0000);
		send_packet(FUNC_SYN, 32'd5, 1'b0, 16'h0000);
		send_packet(FUNC_DATA, 32'd2, 1'b1, 16'hFFFF);
		send_packet(FUNC_DATA, 32'd1, 1'b0, 16'h1111);
		send_packet(FUNC_DATA, 32'd16, 1'b1, 16'h2222);
		send_packet(FUNC_DATA, 32'hFFFFFFFF, 1'b1, 16'h3333);
		send_packet(FUNC_DATA, 32'd1, 1'b1, 16'h0000);
		send_packet(FUNC_DATA, 32'd0, 1'b1, 16'hAAAA);
		send_packet(FUNC_DATA, 32'd0, 1'b1, 16'h4444);
		send_packet(FUNC_DATA, 32'd18, 1'b1, 16'h5555);
		send_packet(FUNC_DATA, 32'd3, 1'b1, 16'h0F0F);
		send_packet(FUNC_FIN, 32'd4, 1'b1, 16'h0000);
		send_packet(FUNC_NONE, 32'hFFFFFFFF, 1'b0, 16'hFFFF);
		// shrink the window with slots filled past its new end
		send_packet(FUNC_SYN, 32'd9, 1'b1, 16'h0000);
		for (k = 1; k <= 5; k++)
			send_data(k);
		write_window(5'd2);
		send_data(32'd0);
		send_data(32'd2);
		send_packet(FUNC_FIN, 32'd9, 1'b1, 16'h0000);

		// random transfers over several window sizes
		first = items_sent;
		for (ph = 0; ph < 10; ph++) begin
			write_window(windows[ph]);
			while (items_sent - first < (ph + 1) * RANDOM_ITEMS / 10)
				run_transfer($urandom_range(1, 40));
		end

		pause_until_drained();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("selective_repeat_receive_reorder_top: match");
		else
			$display("selective_repeat_receive_reorder_top: mismatch");
		$finish;
	end
endmodule
